// ===== hw/rtl/ksbox_pkg.sv =====
`timescale 1ns / 1ps

package ksbox_pkg;

    // opcodes of an input transaction
    localparam logic [1:0] OP_REBUILD = 2'd0;
    localparam logic [1:0] OP_FWD     = 2'd1;
    localparam logic [1:0] OP_INV     = 2'd2;

    // lcg multiplier halves (6364136223846793005)
    localparam logic [31:0] LCG_MULT_HI = 32'h5851_F42D;
    localparam logic [31:0] LCG_MULT_LO = 32'h4C95_7F2D;

    localparam logic [5:0] DIV_LAST_BIT = 6'd63;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK_RD,
        S_LOOK_OUT,
        S_FILL,
        S_MUL_LO,
        S_MUL_HI,
        S_MUL_X,
        S_DIV,
        S_RD_N,
        S_RD_P,
        S_WR_N,
        S_WR_P,
        S_INV_RD,
        S_INV_WR,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_PICK,
        RD_BYTE
    } rd_sel_t;

    typedef struct packed {
        logic    accept;
        logic    seed_from_key;
        logic    fill_we;
        logic    mul_lo;
        logic    mul_hi;
        logic    mul_x;
        logic    div_step;
        rd_sel_t rd_sel;
        logic    latch_vn;
        logic    wr_n;
        logic    wr_pick;
        logic    inv_we;
        logic    emit;
        logic    set_ready;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       idx_zero;
        logic       idx_one;
        logic       idx_max;
        logic       div_last;
        logic       out_free;
    } status_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

endpackage

// ===== hw/rtl/ksbox_ram.sv =====
`timescale 1ns / 1ps

module ksbox_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/ksbox_ctrl.sv =====
`timescale 1ns / 1ps

module ksbox_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ksbox_pkg::status_t st,
    output ksbox_pkg::cmd_t    cmd
);
    import ksbox_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (st.op == OP_REBUILD) ? S_FILL : S_LOOK_RD;
                end
            end
            S_LOOK_RD:  state_next = S_LOOK_OUT;
            S_LOOK_OUT: if (st.out_free) state_next = S_IDLE;
            S_FILL:     if (st.idx_zero) state_next = S_MUL_LO;
            S_MUL_LO:   state_next = S_MUL_HI;
            S_MUL_HI:   state_next = S_MUL_X;
            S_MUL_X:    state_next = S_DIV;
            S_DIV:      if (st.div_last) state_next = S_RD_N;
            S_RD_N:     state_next = S_RD_P;
            S_RD_P:     state_next = S_WR_N;
            S_WR_N:     state_next = S_WR_P;
            S_WR_P:     state_next = st.idx_one ? S_INV_RD : S_MUL_LO;
            S_INV_RD:   state_next = S_INV_WR;
            S_INV_WR:   state_next = st.idx_max ? S_DONE : S_INV_RD;
            S_DONE:     if (st.out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        cmd.rd_sel = RD_IDX;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready          = 1'b1;
                cmd.accept        = in_valid;
                cmd.seed_from_key = in_valid;
            end
            S_LOOK_RD:  cmd.rd_sel = RD_BYTE;
            S_LOOK_OUT:
            begin
                cmd.rd_sel = RD_BYTE;
                cmd.emit   = st.out_free;
            end
            S_FILL:     cmd.fill_we = 1'b1;
            S_MUL_LO:   cmd.mul_lo = 1'b1;
            S_MUL_HI:   cmd.mul_hi = 1'b1;
            S_MUL_X:    cmd.mul_x = 1'b1;
            S_DIV:      cmd.div_step = 1'b1;
            S_RD_N:     cmd.rd_sel = RD_IDX;
            S_RD_P:
            begin
                cmd.rd_sel   = RD_PICK;
                cmd.latch_vn = 1'b1;
            end
            S_WR_N:     cmd.wr_n = 1'b1;
            S_WR_P:     cmd.wr_pick = 1'b1;
            S_INV_RD:   cmd.rd_sel = RD_IDX;
            S_INV_WR:   cmd.inv_we = 1'b1;
            S_DONE:
            begin
                cmd.emit      = st.out_free;
                cmd.set_ready = st.out_free;
            end
            default:    cmd = '0;
        endcase
    end

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> st.out_free)
        else $error("result loaded while output register busy");

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL_X) |=> (state_reg == S_DIV) ##63 (state_reg == S_DIV)
            ##1 (state_reg == S_RD_N))
        else $error("division did not take 64 steps");

endmodule

// ===== hw/rtl/ksbox_dp.sv =====
`timescale 1ns / 1ps

module ksbox_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  ksbox_pkg::cmd_t    cmd,
    output ksbox_pkg::status_t st,
    input  logic               cfg_write_en,
    input  logic [63:0]        cfg_write_data,
    input  logic [1:0]         opcode,
    input  logic [7:0]         data_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         result_byte,
    output logic               table_ready
);
    import ksbox_pkg::*;

    logic [63:0] key_reg;
    logic [63:0] seed_reg,  seed_next;
    logic [63:0] acc_reg,   acc_next;
    logic [7:0]  rem_reg,   rem_next;
    logic [5:0]  cnt_reg,   cnt_next;
    logic [7:0]  idx_reg,   idx_next;
    logic [7:0]  vn_reg;
    logic [1:0]  op_reg;
    logic [7:0]  byte_reg;
    logic        ready_reg;
    logic        out_valid_reg;
    logic [7:0]  result_reg;
    logic        table_ready_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [8:0]  divisor, trial;
    logic [7:0]  rd_addr;
    logic [7:0]  fwd_rdata, inv_rdata;
    logic        fwd_we;
    logic [7:0]  fwd_waddr, fwd_wdata;
    logic [7:0]  result_val;

    // one 32x32 multiplier, three passes per lcg step
    assign mul_a = cmd.mul_hi ? seed_reg[63:32] : seed_reg[31:0];
    assign mul_b = cmd.mul_x ? LCG_MULT_HI : LCG_MULT_LO;
    assign prod  = mul_a * mul_b;

    // restoring remainder, one dividend bit a cycle
    assign divisor = {1'b0, idx_reg} + 9'd1;
    assign trial   = {rem_reg, seed_reg[cnt_reg]};

    always_comb
    begin
        seed_next = seed_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        if (cmd.seed_from_key && (opcode == OP_REBUILD))
        begin
            seed_next = key_reg;
        end
        if (cmd.mul_lo)
        begin
            acc_next = prod + 64'd1;
        end
        if (cmd.mul_hi)
        begin
            acc_next[63:32] = acc_reg[63:32] + prod[31:0];
        end
        if (cmd.mul_x)
        begin
            seed_next = {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
            rem_next  = '0;
            cnt_next  = DIV_LAST_BIT;
        end
        if (cmd.div_step)
        begin
            rem_next = (trial >= divisor) ? 8'(trial - divisor) : trial[7:0];
            cnt_next = cnt_reg - 6'd1;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.accept)
        begin
            idx_next = 8'hFF;
        end
        else if (cmd.fill_we || cmd.wr_pick)
        begin
            idx_next = idx_reg - 8'd1;
        end
        else if (cmd.inv_we)
        begin
            idx_next = idx_reg + 8'd1;
        end
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_PICK: rd_addr = rem_reg;
            RD_BYTE: rd_addr = byte_reg;
            default: rd_addr = idx_reg;
        endcase
    end

    assign fwd_we    = cmd.fill_we | cmd.wr_n | cmd.wr_pick;
    assign fwd_waddr = cmd.wr_pick ? rem_reg : idx_reg;
    assign fwd_wdata = cmd.fill_we ? SBOX[idx_reg] : (cmd.wr_n ? fwd_rdata : vn_reg);

    ksbox_ram #(.WIDTH(8), .DEPTH(256)) u_fwd_ram (
        .clk   (clk),
        .we    (fwd_we),
        .waddr (fwd_waddr),
        .wdata (fwd_wdata),
        .raddr (rd_addr),
        .rdata (fwd_rdata)
    );

    ksbox_ram #(.WIDTH(8), .DEPTH(256)) u_inv_ram (
        .clk   (clk),
        .we    (cmd.inv_we),
        .waddr (fwd_rdata),
        .wdata (idx_reg),
        .raddr (rd_addr),
        .rdata (inv_rdata)
    );

    always_comb
    begin
        result_val = '0;
        if (ready_reg && (op_reg == OP_FWD))
        begin
            result_val = fwd_rdata;
        end
        else if (ready_reg && (op_reg == OP_INV))
        begin
            result_val = inv_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg         <= '0;
            seed_reg        <= '0;
            ready_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            table_ready_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                key_reg <= cfg_write_data;
            end
            seed_reg <= seed_next;
            if (cmd.set_ready)
            begin
                ready_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg   <= 1'b1;
                table_ready_reg <= ready_reg | cmd.set_ready;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        idx_reg <= idx_next;
        if (cmd.latch_vn)
        begin
            vn_reg <= fwd_rdata;
        end
        if (cmd.accept)
        begin
            op_reg   <= opcode;
            byte_reg <= data_byte;
        end
        if (cmd.emit)
        begin
            result_reg <= result_val;
        end
    end

    assign st.op       = opcode;
    assign st.idx_zero = (idx_reg == 8'd0);
    assign st.idx_one  = (idx_reg == 8'd1);
    assign st.idx_max  = (idx_reg == 8'hFF);
    assign st.div_last = (cnt_reg == 6'd0);
    assign st.out_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign result_byte = result_reg;
    assign table_ready = table_ready_reg;

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> ({1'b0, rem_reg} < divisor))
        else $error("remainder out of range");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.fill_we, cmd.wr_n, cmd.wr_pick, cmd.inv_we}))
        else $error("conflicting table writes");

    a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |=> ready_reg)
        else $error("ready flag dropped");

endmodule

// ===== hw/rtl/keyed_sbox_shuffle_lookup_unit.sv =====
`timescale 1ns / 1ps
// channel  | signals                              | direction
// ---------+--------------------------------------+----------
// input    | in_valid, in_ready, opcode, data_byte | in
// output   | out_valid, out_ready, result_byte,    | out
//          | table_ready                          |
// config   | cfg_write_en, cfg_write_data          | in
//
// a lookup transaction passes through address capture, registered table read
// and result load into the output register
// a rebuild runs 256 fill writes, then 255 shuffle steps (three passes of the
// 32x32 multiplier for the lcg, a bit-serial remainder over the 64-bit seed,
// four table accesses), then a pass writing the inverse table
// input is accepted only while the controller is idle; a result waiting on a
// stalled output holds the next transaction in its final state
// asynchronous active-low reset clears control, key, seed and ready flag;
// table contents are not cleared

module keyed_sbox_shuffle_lookup_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [63:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  result_byte,
    output logic        table_ready
);
    import ksbox_pkg::*;

    // command and status bus between sequencer and datapath
    cmd_t    cmd;
    status_t st;

    // sequencer: idle/lookup path plus the rebuild sweep
    ksbox_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath: key, lcg, remainder unit, both tables and the output register
    ksbox_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .opcode         (opcode),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_byte    (result_byte),
        .table_ready    (table_ready)
    );

endmodule
